FILE: rtl/des_ks_pkg.sv
// Package with the DES key schedule tables, types and permutation functions.
package des_ks_pkg;

	// Key bit selection that drops the parity bits: key bit numbers, bit 1 being the most
	// significant.
	localparam byte unsigned PC1_TAB [56] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	// Subkey compression selection: bit numbers within the joined C and D halves.
	localparam byte unsigned PC2_TAB [48] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	// Bit i is set when round i+1 rotates by two places; the first two rounds, the ninth
	// and the last rotate by one.
	localparam logic [15:0] ROT_TWO = 16'h7EFC;

	localparam int unsigned HALF_W  = 28;
	localparam int unsigned CD_W    = 56;
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned SUBKEY_W = 48;
	localparam int unsigned ROUND_W = 5;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd16;

	typedef logic [CD_W-1:0]     cd_t;
	typedef logic [ROUND_W-1:0]  round_t;

	// Control from the top level to the round engine.
	typedef struct packed {
		logic load;
		logic adv;
	} rnd_ctl_t;

	// Status from the round engine to the top level.
	typedef struct packed {
		logic valid;
		logic last;
	} rnd_stat_t;

	// Key bit selection of a 64-bit key into the joined halves.
	function automatic cd_t pc1(input logic [KEY_W-1:0] key);
		cd_t r;
		for (int i = 0; i < 56; i++) begin
			r[55-i] = key[6'(64 - int'(PC1_TAB[i]))];
		end
		return r;
	endfunction

	// Subkey compression of the joined halves.
	function automatic logic [SUBKEY_W-1:0] pc2(input cd_t cd);
		logic [SUBKEY_W-1:0] r;
		for (int i = 0; i < 48; i++) begin
			r[47-i] = cd[6'(56 - int'(PC2_TAB[i]))];
		end
		return r;
	endfunction

	// Rotate both 28-bit halves left by one or two places.
	function automatic cd_t rot_cd(input cd_t cd, input logic two);
		logic [HALF_W-1:0] c;
		logic [HALF_W-1:0] d;
		c = cd[55:28];
		d = cd[27:0];
		if (two) begin
			return {c[25:0], c[27:26], d[25:0], d[27:26]};
		end
		return {c[26:0], c[27], d[26:0], d[27]};
	endfunction

endpackage

FILE: rtl/des_ks_if.sv
// Handshake interfaces for the key channel and the subkey channel.
interface des_ks_key_if;
	logic        valid;
	logic        ready;
	logic [63:0] key_word;

	modport source (output valid, output key_word, input ready);
	modport sink (input valid, input key_word, output ready);
endinterface

interface des_ks_subkey_if;
	logic        valid;
	logic        ready;
	logic [47:0] subkey;
	logic [4:0]  round_number;
	logic        last_subkey;

	modport source (output valid, output subkey, output round_number, output last_subkey,
		input ready);
	modport sink (input valid, input subkey, input round_number, input last_subkey,
		output ready);
endinterface

FILE: rtl/des_key_schedule_top.sv
// Top level of the DES key schedule: key stage, round engine and subkey output register.
// A key's subkeys pass from the key stage through the round engine into the output register.
// Each key yields sixteen subkeys back to back while the output is not held.
// The round engine serves one key at a time and takes a new key when it is empty or its
// last round moves on. Keys are held in a one-entry stage ahead of it while it works.
// Reset clears all valid bits; no state is kept from one key to the next.
module des_key_schedule_top (
	input logic            clk,
	input logic            arst_n,
	des_ks_key_if.sink     keys,
	des_ks_subkey_if.source subkeys
);

	logic                      valid_s1;
	des_ks_pkg::cd_t           cd_s1;
	logic                      valid_s3;
	logic [47:0]               subkey_s3;
	des_ks_pkg::round_t        round_s3;
	logic                      last_s3;

	des_ks_pkg::rnd_ctl_t      rnd_ctl;
	des_ks_pkg::rnd_stat_t     rnd_stat;
	des_ks_pkg::cd_t           rnd_cd;
	des_ks_pkg::round_t        rnd_round;
	logic                      adv3;

	// Stage movement: output register frees up when empty or taken.
	assign adv3         = !valid_s3 || subkeys.ready;
	assign rnd_ctl.adv  = adv3;
	assign rnd_ctl.load = valid_s1 && (!rnd_stat.valid || (adv3 && rnd_stat.last));
	assign keys.ready   = !valid_s1 || rnd_ctl.load;

	// Key stage: key bit selection of the accepted key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.valid && keys.ready) begin
			valid_s1 <= 1'b1;
		end else if (rnd_ctl.load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			cd_s1 <= des_ks_pkg::pc1(keys.key_word);
		end
	end

	des_ks_rounds u_rounds (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (rnd_ctl),
		.cd_in        (cd_s1),
		.stat         (rnd_stat),
		.cd           (rnd_cd),
		.round_number (rnd_round)
	);

	// Output register: subkey compression of the current round's halves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= rnd_stat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && rnd_stat.valid) begin
			subkey_s3 <= des_ks_pkg::pc2(rnd_cd);
			round_s3  <= rnd_round;
			last_s3   <= rnd_stat.last;
		end
	end

	assign subkeys.valid        = valid_s3;
	assign subkeys.subkey       = subkey_s3;
	assign subkeys.round_number = round_s3;
	assign subkeys.last_subkey  = last_s3;

endmodule

FILE: rtl/des_ks_rounds.sv
// Round engine: holds the rotated halves of one key and steps through the sixteen rounds.
module des_ks_rounds (
	input  logic                  clk,
	input  logic                  arst_n,
	input  des_ks_pkg::rnd_ctl_t  ctl,
	input  des_ks_pkg::cd_t       cd_in,
	output des_ks_pkg::rnd_stat_t stat,
	output des_ks_pkg::cd_t       cd,
	output des_ks_pkg::round_t    round_number
);

	logic               valid_s2;
	des_ks_pkg::cd_t    cd_s2;
	des_ks_pkg::round_t rnd_s2;
	logic               last;

	assign last = (rnd_s2 == des_ks_pkg::LAST_ROUND);

	// Valid bit: set on a new key, cleared once the last round has moved on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rnd_s2   <= '0;
		end else if (ctl.load) begin
			valid_s2 <= 1'b1;
			rnd_s2   <= 5'd1;
		end else if (ctl.adv && valid_s2) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				rnd_s2 <= rnd_s2 + 5'd1;
			end
		end
	end

	// Halves: first round rotates by one, later rounds by the schedule.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cd_s2 <= des_ks_pkg::rot_cd(cd_in, 1'b0);
		end else if (ctl.adv && valid_s2 && !last) begin
			cd_s2 <= des_ks_pkg::rot_cd(cd_s2, des_ks_pkg::ROT_TWO[rnd_s2[3:0]]);
		end
	end

	assign stat.valid   = valid_s2;
	assign stat.last    = last;
	assign cd           = cd_s2;
	assign round_number = rnd_s2;

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the DES key schedule: special keys, output stalls and random keys.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected subkey transaction.
	typedef struct packed {
		logic [47:0] subkey;
		logic [4:0]  round_number;
		logic        last_subkey;
	} subkey_rec_t;

	// Key bit taken by each position of the first selection, bit 1 being the MSB.
	localparam byte unsigned KEY_SELECT [56] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	// Bit of the joined halves taken by each subkey position.
	localparam byte unsigned HALVES_SELECT [48] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	// Bit r is set when round r+1 rotates by a single place (rounds 1, 2, 9 and 16).
	localparam logic [15:0] SINGLE_SHIFT_ROUNDS = 16'h8103;
	localparam int unsigned ROUND_COUNT = 16;
	localparam int unsigned IDLE_PERCENT = 31;
	localparam int unsigned RANDOM_KEYS = 89;
	localparam int unsigned STEADY_KEYS = 25;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	des_ks_key_if    keys_ch ();
	des_ks_subkey_if subkeys_ch ();

	des_key_schedule_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys_ch),
		.subkeys (subkeys_ch)
	);

	subkey_rec_t pending_subkeys [$];
	int unsigned mismatch_count = 0;
	int unsigned stall_request = 0;
	bit          steady_flow = 1'b0;

	always #5 clk = ~clk;

	// Work out the sixteen subkeys of a key and queue them in round order.
	function automatic void expand_key_schedule(input logic [63:0] key);
		logic [55:0] selected;
		logic [27:0] c_half;
		logic [27:0] d_half;
		logic [55:0] joined;
		logic [47:0] round_key;
		int unsigned step;
		for (int i = 0; i < 56; i++) begin
			selected[55 - i] = key[64 - int'(KEY_SELECT[i])];
		end
		c_half = selected[55:28];
		d_half = selected[27:0];
		for (int r = 0; r < ROUND_COUNT; r++) begin
			step = SINGLE_SHIFT_ROUNDS[r] ? 1 : 2;
			c_half = (c_half << step) | (c_half >> (28 - step));
			d_half = (d_half << step) | (d_half >> (28 - step));
			joined = {c_half, d_half};
			for (int j = 0; j < 48; j++) begin
				round_key[47 - j] = joined[56 - int'(HALVES_SELECT[j])];
			end
			pending_subkeys.push_back('{round_key, 5'(r + 1), r == ROUND_COUNT - 1});
		end
	endfunction

	task automatic flag_mismatch(input string field, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("Mismatch in %s: expected %h, got %h", field, want, got);
		end
	endtask

	// Offer one key, with random gaps unless the flow is steady, and wait for its transaction.
	task automatic send_key(input logic [63:0] key);
		if (!steady_flow) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				keys_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		keys_ch.valid <= 1'b1;
		keys_ch.key_word <= key;
		do begin
			@(posedge clk);
		end while (!(keys_ch.valid && keys_ch.ready));
		expand_key_schedule(key);
	endtask

	// Stop offering keys until every expected subkey has come back.
	task automatic wait_for_subkeys();
		keys_ch.valid <= 1'b0;
		while (pending_subkeys.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// All-zero, all-one, weak and semi-weak keys, single bits and parity-only patterns.
	task automatic test_special_keys();
		logic [63:0] special [$];
		special = '{
			64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
			64'h1F1F_1F1F_0E0E_0E0E, 64'hE0E0_E0E0_F1F1_F1F1,
			64'h01FE_01FE_01FE_01FE, 64'h1FE0_1FE0_0EF1_0EF1,
			64'h1334_5779_9BBC_DFF1, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000,
			64'h0000_0000_0000_0001, 64'h0000_0000_0000_0080,
			64'h7F7F_7F7F_7F7F_7F7F, 64'h0F0F_0F0F_F0F0_F0F0
		};
		steady_flow = 1'b1;
		foreach (special[i]) begin
			send_key(special[i]);
		end
		wait_for_subkeys();
		steady_flow = 1'b0;
	endtask

	// Hold the subkey side off for a long stretch while keys keep coming, so the block fills up.
	task automatic test_output_stall();
		stall_request = 80;
		@(posedge clk);
		steady_flow = 1'b1;
		repeat (5) begin
			send_key({$urandom, $urandom});
		end
		steady_flow = 1'b0;
		wait_for_subkeys();
	endtask

	// Random keys: a stretch with no idling on either side, then random gaps on both.
	task automatic test_random_keys();
		steady_flow = 1'b1;
		for (int n = 0; n < RANDOM_KEYS; n++) begin
			if (n == STEADY_KEYS) begin
				steady_flow = 1'b0;
			end
			send_key({$urandom, $urandom});
		end
		wait_for_subkeys();
	endtask

	// Subkey side readiness: long holds on request, otherwise random or steady.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		subkeys_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				stall_left = stall_request;
				stall_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				subkeys_ch.ready <= 1'b0;
			end else if (steady_flow) begin
				subkeys_ch.ready <= 1'b1;
			end else begin
				subkeys_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Compare each subkey transaction with the oldest expectation.
	always @(posedge clk) begin : check_subkeys
		subkey_rec_t want;
		if (arst_n && subkeys_ch.valid && subkeys_ch.ready) begin
			if (pending_subkeys.size() == 0) begin
				flag_mismatch("unexpected subkey", 64'd0, 64'(subkeys_ch.subkey));
			end else begin
				want = pending_subkeys.pop_front();
				if (subkeys_ch.subkey !== want.subkey) begin
					flag_mismatch("subkey", 64'(want.subkey), 64'(subkeys_ch.subkey));
				end
				if (subkeys_ch.round_number !== want.round_number) begin
					flag_mismatch("round_number", 64'(want.round_number),
						64'(subkeys_ch.round_number));
				end
				if (subkeys_ch.last_subkey !== want.last_subkey) begin
					flag_mismatch("last_subkey", 64'(want.last_subkey),
						64'(subkeys_ch.last_subkey));
				end
			end
		end
	end

	// Reset, the tests in turn, a quiet tail and the verdict.
	initial begin
		keys_ch.valid = 1'b0;
		keys_ch.key_word = 64'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_keys();
		test_output_stall();
		test_random_keys();
		repeat (20) @(posedge clk);
		if (pending_subkeys.size() != 0) begin
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: des_key_schedule_top.f
rtl/des_ks_pkg.sv
rtl/des_ks_if.sv
rtl/des_ks_rounds.sv
rtl/des_key_schedule_top.sv
bench/testbench.sv
